>>> hw/rtl/nls_pkg.sv
// Shared types and constants for the nth-largest selection block.
package nls_pkg;

  // Number of cells in the sorted list.
  localparam int MaxRank = 16;
  // Width of a sample value, signed Q16.16.
  localparam int ValueW  = 32;
  // Width of the rank register.
  localparam int RankW   = 4;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [RankW-1:0]         rank_t;

  // What one cell hands to the next cell down the list.
  typedef struct packed {
    logic   take;   // the new value belongs at or above this cell
    logic   valid;  // this cell holds a kept value, after any frame clear
    value_t value;  // the value this cell holds now
  } link_t;

endpackage

>>> hw/rtl/nls_if.sv
// Streaming channel interfaces for the input items and the results.
interface nls_in_if;
  import nls_pkg::*;

  logic   valid;
  logic   ready;
  value_t sample_value;
  logic   selected;
  logic   first_item;
  logic   last_item;

  modport source (output valid, sample_value, selected, first_item, last_item,
                  input ready);
  modport sink   (input valid, sample_value, selected, first_item, last_item,
                  output ready);
endinterface

interface nls_out_if;
  import nls_pkg::*;

  logic   valid;
  logic   ready;
  value_t ranked_value;
  logic   found;

  modport source (output valid, ranked_value, found, input ready);
  modport sink   (input valid, ranked_value, found, output ready);
endinterface

>>> hw/rtl/nls_cell.sv
// One cell of the descending sorted list: holds one entry and its valid bit.
module nls_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            ins_i,        // a transaction is accepted this cycle
  input  logic            clear_i,      // first item: empty the list first
  input  logic            selected_i,   // the new value is to be kept
  input  nls_pkg::value_t new_value_i,
  input  nls_pkg::link_t  prev_i,       // from the cell one place higher
  output nls_pkg::link_t  link_o,       // to the cell one place lower
  output logic            valid_o       // stored valid bit, for the rank readout
);
  import nls_pkg::*;

  logic   valid_q, valid_d;
  value_t value_q, value_d;
  logic   valid_eff;
  logic   take;
  logic   upd;

  // A frame start empties the cell before the new value is considered.
  assign valid_eff = valid_q & ~clear_i;

  // The new value lands here or higher when it is strictly larger than the
  // entry, so equal values go after those already kept; empty cells always
  // take.
  assign take = ~valid_eff | (new_value_i > value_q);
  assign upd  = ins_i & selected_i;

  // Shift the higher entry down, place the new value, or hold.
  always_comb begin
    value_d = value_q;
    valid_d = valid_eff;
    if (upd) begin
      if (prev_i.take) begin
        value_d = prev_i.value;
      end else if (take) begin
        value_d = new_value_i;
      end
      valid_d = valid_eff | (take & prev_i.valid);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ins_i) begin
      valid_q <= valid_d;
    end
  end

  // Entry payload needs no reset: it is read only while valid.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o.take  = take;
  assign link_o.valid = valid_eff;
  assign link_o.value = value_q;
  assign valid_o      = valid_q;

endmodule

>>> hw/rtl/nth_largest_selected_in_frame.sv
// Top level of the streaming nth-largest selection block.
//
//   Channel   Dir   Payload                                      Handshake
//   in_i      in    sample_value, selected, first_item, last_item valid/ready
//   out_o     out   ranked_value, found                           valid/ready
//   cfg       in    cfg_wdata_i (rank_n)                          cfg_we_i
//
// One item is taken every cycle while input ready is high; its result is
// registered after the list update in the cell chain and the rank readout.
// The list is a chain of MaxRank cells that all compare against the new
// value at once and shift down by one place where it is inserted.
// Reset clears every cell valid bit, the rank register and the pipeline.
// When the result register is held by the sink, one more item is absorbed
// in the readout stage and then input ready falls.
module nth_largest_selected_in_frame (
  input  logic                clk_i,
  input  logic                rst_ni,
  nls_in_if.sink              in_i,
  nls_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  nls_pkg::rank_t      cfg_wdata_i
);
  import nls_pkg::*;

  rank_t  rank_q;
  logic   ins;
  link_t  links [MaxRank+1];
  logic   [MaxRank-1:0] cell_valid;
  logic   s1_valid_q, s1_last_q;
  logic   s1_move;
  logic   out_valid_q;
  value_t out_value_q, out_value_d;
  logic   out_found_q, out_found_d;

  // Rank register; write it only while the block is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= '0;
    end else if (cfg_we_i) begin
      rank_q <= cfg_wdata_i;
    end
  end

  // Handshake: the readout stage moves whenever the output register is free.
  assign s1_move    = s1_valid_q & (~out_valid_q | out_o.ready);
  assign in_i.ready = ~s1_valid_q | s1_move;
  assign ins        = in_i.valid & in_i.ready;

  // Top of the chain: nothing shifts in, and the first cell may always fill.
  assign links[0].take  = 1'b0;
  assign links[0].valid = 1'b1;
  assign links[0].value = '0;

  // Chain of list cells, largest value in cell 0.
  for (genvar g = 0; g < MaxRank; g++) begin : g_cell
    nls_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ins_i       (ins),
      .clear_i     (in_i.first_item),
      .selected_i  (in_i.selected),
      .new_value_i (in_i.sample_value),
      .prev_i      (links[g]),
      .link_o      (links[g+1]),
      .valid_o     (cell_valid[g])
    );
  end

  // Readout stage: remembers that an item was taken and whether it was last.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= ins;
      s1_last_q  <= in_i.last_item;
    end
  end

  // On a last item, pick the entry at the configured rank from the list,
  // which already holds the item now in the readout stage.
  always_comb begin
    out_value_d = '0;
    out_found_d = 1'b0;
    for (int i = 0; i < MaxRank; i++) begin
      if (int'(rank_q) == i) begin
        out_found_d = s1_last_q & cell_valid[i];
        out_value_d = (s1_last_q & cell_valid[i]) ? links[i+1].value : '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_value_q <= out_value_d;
      out_found_q <= out_found_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.ranked_value = out_value_q;
  assign out_o.found        = out_found_q;

endmodule
